// ----- hw/rtl/box_blur_3x3_edge_aware_top_defines.svh -----
// ============================================================================
// Assertion macros for the box blur block
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ============================================================================
`ifndef BOX_BLUR_3X3_EDGE_AWARE_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BB3_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bb3_pkg.sv -----
// ============================================================================
// Box blur package
// Payload types, widths and register codes shared by the box blur files.
// ============================================================================
`default_nettype none

package bb3_pkg;

  // Default geometry of the line store.
  localparam int MaxWidthDefault  = 1024;
  localparam int StoreRowsDefault = 3;

  // Arithmetic widths of the rounded mean.
  localparam int SumW      = 12;  // up to nine 8-bit samples
  localparam int DividendW = 13;  // 2*sum + n
  localparam int DivisorW  = 5;   // 2*n, at most 18
  localparam int CountW    = 4;   // n, at most 9
  localparam int ChanW     = 8;

  // Register codes, taken from paddr[2].
  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  // Commands of an input transaction.
  localparam logic CmdPixel = 1'b0;
  localparam logic CmdDrain = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [15:0] out_row;
    logic [9:0]  out_column;
    logic        last_of_run;
    logic        frame_done;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bb3_ram.sv -----
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 3072
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bb3_div.sv -----
// ============================================================================
// Rounding divider, three lanes
// Divides by the small divisor set of the blur with shifts and reciprocals.
// ============================================================================
`default_nettype none

module bb3_div
  import bb3_pkg::*;
(
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [2:0][DividendW-1:0]      dividend_i,
  input  wire logic [DivisorW-1:0]            divisor_i,
  output logic                                done_o,
  output logic      [2:0][ChanW-1:0]          quot_o
);

  // Reciprocals for division by three and by nine; both are exact here
  // because the dividends stay far below the reciprocal scale.
  localparam logic [31:0] RecipThree = 32'd43691;  // ceil(2^17 / 3)
  localparam logic [31:0] RecipNine  = 32'd3641;   // ceil(2^15 / 9)

  logic [2:0][ChanW-1:0] quot_q, quot_d;
  logic                  done_q;

  // The divisor is 2, 4, 6, 8, 12 or 18: a shift, then a divide by three or
  // nine where the divisor has such a factor.
  always_comb begin
    logic [DividendW-1:0] half;
    logic [DividendW-1:0] quarter;
    logic [31:0]          prod;
    for (int l = 0; l < 3; l++) begin
      half    = dividend_i[l] >> 1;
      quarter = dividend_i[l] >> 2;
      prod    = '0;
      case (divisor_i)
        5'd2: begin
          quot_d[l] = half[ChanW-1:0];
        end
        5'd4: begin
          quot_d[l] = quarter[ChanW-1:0];
        end
        5'd8: begin
          quot_d[l] = dividend_i[l][ChanW+2:3];
        end
        5'd6: begin
          prod      = 32'(half) * RecipThree;
          quot_d[l] = prod[ChanW+16:17];
        end
        5'd12: begin
          prod      = 32'(quarter) * RecipThree;
          quot_d[l] = prod[ChanW+16:17];
        end
        5'd18: begin
          prod      = 32'(half) * RecipNine;
          quot_d[l] = prod[ChanW+14:15];
        end
        default: begin
          quot_d[l] = half[ChanW-1:0];
        end
      endcase
    end
  end

  // The quotients are registered on the start and are ready in the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- hw/rtl/box_blur_3x3_edge_aware_top.sv -----
// ============================================================================
// Edge-aware 3x3 box blur
// Line store, neighborhood sequencer and divider for an RGB pixel stream.
// ============================================================================
// The block takes RGB pixels in raster order and returns, per channel, the
// rounded mean of the in-frame pixels around each position, one row and one
// column behind the input. For each result the sequencer steps through the
// nine neighbor positions in S_READ, reading the up to nine in-frame neighbors
// one a cycle through the single read port of the line store, then waits in
// S_LAST for the last read data, loads the divider in S_DSTART, waits in S_DIV
// for the rounding divide and holds the result in the output register in S_OUT
// until the receiver takes it. Only one input transaction is in work at a
// time. The line store needs no clearing pass after reset.
`default_nettype none

module box_blur_3x3_edge_aware_top
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidthDefault,
  parameter int STORE_ROWS = StoreRowsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Depth = STORE_ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(Depth);
  localparam int SW    = $clog2(STORE_ROWS);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_LAST, S_DSTART, S_DIV, S_OUT
  } state_e;

  state_e          state_q;
  logic [10:0]     fw_q;
  logic [15:0]     fh_q;
  logic [15:0]     row_q;
  logic [CW-1:0]   col_q;
  logic [SW-1:0]   slot_q;
  logic [CW-1:0]   dcol_q;
  logic            dpend_q;
  logic [15:0]     orow_q;
  logic [CW-1:0]   ocol_q;
  logic [SW-1:0]   oslot_q;
  logic            olast_q;
  logic            odone_q;
  logic            second_q;
  logic [1:0]      dr_q;
  logic [1:0]      dc_q;
  logic [CountW-1:0] n_q;
  logic [2:0][SumW-1:0] acc_q;
  logic            rvld_q;
  out_item_t       out_q;

  // Effective frame size.
  logic [31:0]   w32;
  logic [CW-1:0] wm1;
  logic [15:0]   hm1;
  assign w32 = (fw_q == 11'd0) ? 32'd1 :
               (32'(fw_q) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(fw_q);
  assign wm1 = CW'(w32 - 32'd1);
  assign hm1 = (fh_q == 16'd0) ? 16'd0 : fh_q - 16'd1;

  // Input decode.
  logic in_acc, is_pix, is_drn, row_end, emit1, emit2, drn_done;
  logic [SW-1:0] prev_slot;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_pix     = (in_data_i.command == CmdPixel) && !dpend_q;
  assign is_drn     = (in_data_i.command == CmdDrain) && dpend_q;
  assign row_end    = (col_q == wm1);
  assign emit1      = is_pix && (row_q != 16'd0) && (col_q != '0);
  assign emit2      = is_pix && (row_q != 16'd0) && row_end;
  assign drn_done   = (dcol_q >= wm1);
  assign prev_slot  = (slot_q == '0) ? SW'(STORE_ROWS - 1) : slot_q - 1'b1;

  // Neighbor address and in-frame test.
  logic          nb_valid;
  logic [SW+1:0] nb_sum;
  logic [SW-1:0] nb_slot;
  logic [CW-1:0] nb_col;
  logic [AW-1:0] raddr, waddr;
  always_comb begin
    nb_valid = 1'b1;
    if (dr_q == 2'd0 && orow_q == 16'd0) nb_valid = 1'b0;
    if (dr_q == 2'd2 && orow_q == hm1)   nb_valid = 1'b0;
    if (dc_q == 2'd0 && ocol_q == '0)    nb_valid = 1'b0;
    if (dc_q == 2'd2 && ocol_q == wm1)   nb_valid = 1'b0;
    nb_sum = (SW + 2)'(oslot_q) + (SW + 2)'(dr_q) + (SW + 2)'(STORE_ROWS - 1);
    if (nb_sum >= (SW + 2)'(2 * STORE_ROWS)) begin
      nb_sum = nb_sum - (SW + 2)'(2 * STORE_ROWS);
    end else if (nb_sum >= (SW + 2)'(STORE_ROWS)) begin
      nb_sum = nb_sum - (SW + 2)'(STORE_ROWS);
    end
    nb_slot = nb_sum[SW-1:0];
    nb_col  = ocol_q + CW'(dc_q) - CW'(1);
    raddr   = AW'(32'(nb_slot) * 32'(MAX_WIDTH) + 32'(nb_col));
    waddr   = AW'(32'(slot_q) * 32'(MAX_WIDTH) + 32'(col_q));
  end

  // Line store.
  logic [23:0] rdata;
  bb3_ram #(
    .WIDTH (24),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && is_pix),
    .waddr_i (waddr),
    .wdata_i ({in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in}),
    .re_i    ((state_q == S_READ) && nb_valid),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Divider for the three channel means.
  logic [2:0][DividendW-1:0] dividend;
  logic [2:0][ChanW-1:0]     quot;
  logic                      div_done;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dividend[l] = {acc_q[l], 1'b0} + DividendW'(n_q);
    end
  end

  bb3_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DSTART),
    .dividend_i (dividend),
    .divisor_i  ({n_q, 1'b0}),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Configuration port.
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegFrameHeight) ? {16'd0, fh_q} : {21'd0, fw_q};

  // Sequencer: position tracking, neighbor reads and result hand-off.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fw_q     <= 11'd1;
      fh_q     <= 16'd1;
      row_q    <= '0;
      col_q    <= '0;
      slot_q   <= '0;
      dcol_q   <= '0;
      dpend_q  <= 1'b0;
      second_q <= 1'b0;
      rvld_q   <= 1'b0;
    end else begin
      rvld_q <= (state_q == S_READ) && nb_valid;
      case (state_q)
        S_IDLE: begin
          if (in_acc && is_pix) begin
            if (emit1 || emit2) begin
              state_q <= S_READ;
            end
            second_q <= emit1 && emit2;
            if (row_end) begin
              col_q <= '0;
              if (row_q >= hm1) begin
                dpend_q <= 1'b1;
                dcol_q  <= '0;
              end else begin
                row_q  <= row_q + 16'd1;
                slot_q <= (slot_q == SW'(STORE_ROWS - 1)) ? '0 : slot_q + 1'b1;
              end
            end else begin
              col_q <= col_q + 1'b1;
            end
          end else if (in_acc && is_drn) begin
            state_q  <= S_READ;
            second_q <= 1'b0;
            if (drn_done) begin
              dpend_q <= 1'b0;
              dcol_q  <= '0;
              row_q   <= '0;
              col_q   <= '0;
              slot_q  <= '0;
            end else begin
              dcol_q <= dcol_q + 1'b1;
            end
          end
        end
        S_READ: begin
          if (dr_q == 2'd2 && dc_q == 2'd2) begin
            state_q <= S_LAST;
          end
        end
        S_LAST:   state_q <= S_DSTART;
        S_DSTART: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            if (second_q) begin
              second_q <= 1'b0;
              state_q  <= S_READ;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // A register write restarts the frame; the user must write only while idle, the block does not enforce it.
      if (cfg_wr) begin
        if (paddr[2] == RegFrameWidth) begin
          fw_q <= pwdata[10:0];
        end else begin
          fh_q <= pwdata[15:0];
        end
        row_q   <= '0;
        col_q   <= '0;
        slot_q  <= '0;
        dcol_q  <= '0;
        dpend_q <= 1'b0;
      end
    end
  end

  // Payload registers: center position, accumulators and the result.
  always_ff @(posedge clk_i) begin
    logic [31:0] col32;
    col32 = 32'(ocol_q);
    if (state_q == S_IDLE && in_acc && (emit1 || emit2 || is_drn)) begin
      dr_q    <= '0;
      dc_q    <= '0;
      n_q     <= '0;
      acc_q   <= '0;
      odone_q <= is_drn && drn_done;
      if (is_drn) begin
        orow_q  <= hm1;
        ocol_q  <= dcol_q;
        oslot_q <= slot_q;
        olast_q <= 1'b1;
      end else begin
        orow_q  <= row_q - 16'd1;
        oslot_q <= prev_slot;
        ocol_q  <= emit1 ? col_q - 1'b1 : wm1;
        olast_q <= !(emit1 && emit2);
      end
    end else if (state_q == S_OUT && out_ready_i && second_q) begin
      dr_q    <= '0;
      dc_q    <= '0;
      n_q     <= '0;
      acc_q   <= '0;
      ocol_q  <= wm1;
      olast_q <= 1'b1;
    end else begin
      if (state_q == S_READ) begin
        if (nb_valid) begin
          n_q <= n_q + 1'b1;
        end
        if (dc_q == 2'd2) begin
          dc_q <= '0;
          dr_q <= dr_q + 2'd1;
        end else begin
          dc_q <= dc_q + 2'd1;
        end
      end
      if (rvld_q) begin
        acc_q[0] <= acc_q[0] + SumW'(rdata[23:16]);
        acc_q[1] <= acc_q[1] + SumW'(rdata[15:8]);
        acc_q[2] <= acc_q[2] + SumW'(rdata[7:0]);
      end
    end
    if (state_q == S_DIV && div_done) begin
      out_q.red_out     <= quot[0];
      out_q.green_out   <= quot[1];
      out_q.blue_out    <= quot[2];
      out_q.out_row     <= orow_q;
      out_q.out_column  <= col32[9:0];
      out_q.last_of_run <= olast_q;
      out_q.frame_done  <= odone_q;
    end
  end

  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bb3_checker.sv -----
// ============================================================================
// Box blur port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ============================================================================
`default_nettype none

`include "box_blur_3x3_edge_aware_top_defines.svh"

module bb3_checker
  import bb3_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire out_item_t   out_data_o,
  input wire logic        psel,
  input wire logic        pready
);

  // A pending result transaction holds until it is taken.
  `BB3_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

  // A pending result keeps its payload until it is taken.
  `BB3_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o), "result changed")

  // A new input transaction is never taken while a result waits.
  `BB3_ASSERT_SAME(a_no_overlap, out_valid_o, !in_ready_o, "input taken during result")

  // The last pixel of a frame always closes its run.
  `BB3_ASSERT_SAME(a_done_last, out_valid_o && out_data_o.frame_done,
                   out_data_o.last_of_run, "frame end without run end")

  // The register port never inserts wait states.
  `BB3_ASSERT_SAME(a_pready, psel, pready, "register port stalled")

endmodule

bind box_blur_3x3_edge_aware_top bb3_checker u_checker (.*);

`default_nettype wire

// ----- dv/tb.sv -----
// ============================================================================
// Box blur stream testbench
// Drives RGB pixel frames and drain ticks through the blur block, predicts
// each blurred pixel from its own copy of the line store, and checks results.
// ============================================================================
`default_nettype none

module tb;
  import bb3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxW       = 1024;
  localparam int CycleLimit = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  box_blur_3x3_edge_aware_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Predictor state: its own line store, position and frame registers.
  logic [23:0] pix_store [3*MaxW];
  int unsigned cur_row, cur_col, drain_col;
  bit          draining;
  logic [10:0] width_reg = 11'd1;
  logic [15:0] height_reg = 16'd1;

  out_item_t   blur_expected [$];
  int          errors = 0;
  int          results_seen = 0;
  int          pixels_sent = 0;
  int          cycles = 0;
  bit          hold_off = 1'b0;

  function automatic int unsigned frame_w();
    if (width_reg < 1) return 1;
    if (width_reg > MaxW) return MaxW;
    return width_reg;
  endfunction

  function automatic int unsigned frame_h();
    return (height_reg < 1) ? 1 : height_reg;
  endfunction

  // Blurred pixel at (row, col): rounded-half-up mean of in-frame neighbors.
  function automatic out_item_t blur_at(int unsigned row, int unsigned col,
                                        bit last, bit done);
    out_item_t   res;
    int unsigned sr, sg, sb, n;
    int          rr, cc;
    logic [23:0] v;
    sr = 0; sg = 0; sb = 0; n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = int'(row) + dr;
        cc = int'(col) + dc;
        if (rr >= 0 && cc >= 0 && rr < int'(frame_h()) && cc < int'(frame_w())) begin
          v = pix_store[(rr % 3) * MaxW + cc];
          sr += v[23:16]; sg += v[15:8]; sb += v[7:0];
          n++;
        end
      end
    end
    if (n == 0) n = 1;
    res.red_out     = 8'((2 * sr + n) / (2 * n));
    res.green_out   = 8'((2 * sg + n) / (2 * n));
    res.blue_out    = 8'((2 * sb + n) / (2 * n));
    res.out_row     = 16'(row);
    res.out_column  = 10'(col);
    res.last_of_run = last;
    res.frame_done  = done;
    return res;
  endfunction

  // Advance the predictor by one accepted transaction.
  function automatic void predict_blur(in_item_t it);
    int unsigned w, h;
    bit          row_end, done;
    w = frame_w();
    h = frame_h();
    if (it.command == CmdDrain) begin
      if (!draining) return;
      done = (drain_col >= w - 1);
      blur_expected.push_back(blur_at(h - 1, drain_col, 1'b1, done));
      if (done) begin
        draining = 0; drain_col = 0; cur_row = 0; cur_col = 0;
      end else begin
        drain_col++;
      end
      return;
    end
    if (draining) return;
    row_end = (cur_col == w - 1);
    pix_store[(cur_row % 3) * MaxW + cur_col] = {it.red_in, it.green_in, it.blue_in};
    if (cur_row >= 1) begin
      if (cur_col >= 1)
        blur_expected.push_back(blur_at(cur_row - 1, cur_col - 1, !row_end, 1'b0));
      if (row_end)
        blur_expected.push_back(blur_at(cur_row - 1, w - 1, 1'b1, 1'b0));
    end
    if (row_end) begin
      cur_col = 0;
      if (cur_row >= h - 1) begin
        draining = 1; drain_col = 0;
      end else begin
        cur_row++;
      end
    end else begin
      cur_col++;
    end
  endfunction

  // Random gap: mostly short, sometimes long, often none.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one transaction with an optional idle gap before it. Valid stays
  // high after acceptance until the next gap, transaction or idle wait.
  task automatic send_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           bit gaps = 1'b1);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, red_in: r, green_in: g, blue_in: b};
    do @(posedge clk); while (!in_ready);
    predict_blur('{command: cmd, red_in: r, green_in: g, blue_in: b});
    if (cmd == CmdPixel) pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_pixel(bit gaps = 1'b1);
    send_item(CmdPixel, 8'($urandom), 8'($urandom), 8'($urandom), gaps);
  endtask

  // Drop the input, wait until every expected result has arrived, then let
  // the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (blur_expected.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // APB register write: setup cycle, then access cycle.
  task automatic write_reg(logic reg_code, logic [31:0] value);
    wait_idle();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_code, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (reg_code == RegFrameWidth) width_reg = value[10:0];
    else height_reg = value[15:0];
    cur_row = 0; cur_col = 0; drain_col = 0; draining = 0;
  endtask

  // One full frame: pixels, then drain ticks, with some noise mixed in if noise is set.
  task automatic run_frame(bit noise);
    int unsigned total;
    total = frame_w() * frame_h();
    for (int unsigned i = 0; i < total; i++) begin
      if (noise && $urandom_range(0, 19) == 0)
        send_item(CmdDrain, 8'($urandom), 8'($urandom), 8'($urandom));
      send_pixel();
    end
    for (int unsigned i = 0; i < frame_w(); i++) begin
      if (noise && $urandom_range(0, 9) == 0) send_pixel();
      send_item(CmdDrain, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Directed: channel extremes, edge geometry and ignored commands.
  task automatic test_directed();
    write_reg(RegFrameWidth, 32'd3);
    write_reg(RegFrameHeight, 32'd3);
    send_item(CmdDrain, 8'hFF, 8'hFF, 8'hFF);
    send_item(CmdPixel, 8'hFF, 8'h00, 8'hFF);
    send_item(CmdPixel, 8'h00, 8'hFF, 8'h00);
    send_item(CmdPixel, 8'hFF, 8'hFF, 8'hFF);
    send_item(CmdPixel, 8'h01, 8'h00, 8'h80);
    send_item(CmdPixel, 8'hFE, 8'h7F, 8'h01);
    send_item(CmdPixel, 8'hFF, 8'hFF, 8'h00);
    send_item(CmdPixel, 8'h00, 8'h00, 8'h00);
    send_item(CmdPixel, 8'hAA, 8'h55, 8'hFF);
    send_item(CmdPixel, 8'h55, 8'hAA, 8'h01);
    send_item(CmdPixel, 8'h12, 8'h34, 8'h56);
    send_item(CmdDrain, 8'h00, 8'h00, 8'h00);
    send_item(CmdDrain, 8'h00, 8'h00, 8'h00);
    send_item(CmdDrain, 8'h00, 8'h00, 8'h00);
    send_item(CmdDrain, 8'h00, 8'h00, 8'h00);
  endtask

  // Register extremes: zero and oversized width, zero height, single pixel.
  task automatic test_register_extremes();
    write_reg(RegFrameWidth, 32'd0);
    write_reg(RegFrameHeight, 32'd0);
    run_frame(1'b0);
    write_reg(RegFrameWidth, 32'h7FF);
    write_reg(RegFrameHeight, 32'd2);
    for (int i = 0; i < 5; i++) send_pixel();
    write_reg(RegFrameWidth, 32'd1);
    write_reg(RegFrameHeight, 32'd5);
    run_frame(1'b0);
    write_reg(RegFrameWidth, 32'd6);
    write_reg(RegFrameHeight, 32'd1);
    run_frame(1'b0);
    write_reg(RegFrameHeight, 32'hFFFF);
    for (int i = 0; i < 20; i++) send_pixel();
  endtask

  // Wide rows: one frame of two long rows, sent back to back.
  task automatic test_wide_frame();
    write_reg(RegFrameWidth, 32'd100);
    write_reg(RegFrameHeight, 32'd2);
    for (int i = 0; i < 200; i++) send_pixel(1'b0);
    for (int i = 0; i < 100; i++)
      send_item(CmdDrain, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
  endtask

  // Back-pressure: receiver holds off while the sender keeps offering.
  task automatic test_backpressure();
    write_reg(RegFrameWidth, 32'd4);
    write_reg(RegFrameHeight, 32'd3);
    hold_off = 1'b1;
    run_frame(1'b0);
    hold_off = 1'b0;
  endtask

  // Random frames of small random sizes, with stray items mixed in.
  task automatic test_random_frames();
    while (pixels_sent < 600) begin
      write_reg(RegFrameWidth, $urandom_range(1, 9));
      write_reg(RegFrameHeight, $urandom_range(1, 7));
      if ($urandom_range(0, 7) == 0) begin
        for (int i = $urandom_range(1, 12); i > 0; i--) send_pixel();
      end else begin
        run_frame(1'b1);
      end
    end
  endtask

  // Output side: random stalls, plus a long hold-off when requested.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        for (int c = 0; c < 300; c++) @(negedge clk);
        out_ready <= 1'b1;
        wait (!hold_off);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(negedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (blur_expected.size() == 0) begin
        $error("unexpected result row %0d col %0d", out_data.out_row, out_data.out_column);
        errors++;
      end else begin
        e = blur_expected.pop_front();
        if (out_data.red_out !== e.red_out) begin
          $error("red_out: expected %0d, got %0d", e.red_out, out_data.red_out); errors++;
        end
        if (out_data.green_out !== e.green_out) begin
          $error("green_out: expected %0d, got %0d", e.green_out, out_data.green_out);
          errors++;
        end
        if (out_data.blue_out !== e.blue_out) begin
          $error("blue_out: expected %0d, got %0d", e.blue_out, out_data.blue_out); errors++;
        end
        if (out_data.out_row !== e.out_row) begin
          $error("out_row: expected %0d, got %0d", e.out_row, out_data.out_row); errors++;
        end
        if (out_data.out_column !== e.out_column) begin
          $error("out_column: expected %0d, got %0d", e.out_column, out_data.out_column);
          errors++;
        end
        if (out_data.last_of_run !== e.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", e.last_of_run, out_data.last_of_run);
          errors++;
        end
        if (out_data.frame_done !== e.frame_done) begin
          $error("frame_done: expected %0d, got %0d", e.frame_done, out_data.frame_done);
          errors++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("box_blur_3x3_edge_aware_top: mismatch");
      $finish;
    end
  end

  initial begin
    cur_row = 0; cur_col = 0; drain_col = 0; draining = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_wide_frame();
    test_random_frames();
    wait_idle();
    if (blur_expected.size() != 0) errors++;
    $display("Sent %0d pixels over frames of many sizes; checked %0d blurred results.",
             pixels_sent, results_seen);
    if (errors == 0) begin
      $display("box_blur_3x3_edge_aware_top: match");
    end else begin
      $display("box_blur_3x3_edge_aware_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
